[design/b64_pkg.sv]
// Package for the base64 stream codec: transfer payload types, burst type,
// alphabet constants and the character/symbol mapping functions.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package b64_pkg;

    // One input transfer: a raw byte (encode) or a text character (decode).
    typedef struct packed {
        logic [7:0] in_data;
        logic       is_last;
    } t_in_item;

    // One output transfer.
    typedef struct packed {
        logic [7:0] out_data;
        logic       out_last;
        logic       bad_input;
    } t_out_item;

    // Largest number of results one input item can cause, and its count width.
    localparam int unsigned BurstMax  = 4;
    localparam int unsigned BurstCntW = 3;

    // Results of one input item, first result in items[0].
    typedef struct packed {
        t_out_item [BurstMax-1:0] items;
        logic [BurstCntW-1:0]     count;
    } t_burst;

    // Direction register codes.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // ASCII codes used by the alphabet.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Offsets of the alphabet ranges within the six-bit symbol space.
    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SYM_PLUS       = 6'd62;
    localparam logic [5:0] SYM_SLASH      = 6'd63;

    // Classified input character.
    typedef struct packed {
        logic       is_bad;
        logic       is_pad;
        logic [5:0] value;
    } t_sym;

    // Six-bit symbol to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] sym);
        logic [7:0] sym_w;
        logic [7:0] ch;
        sym_w = {2'b00, sym};
        if (sym < SYM_LOWER_BASE) begin
            ch = CHAR_UPPER_A + sym_w;
        end else if (sym < SYM_DIGIT_BASE) begin
            ch = CHAR_LOWER_A + sym_w - {2'b00, SYM_LOWER_BASE};
        end else if (sym < SYM_PLUS) begin
            ch = CHAR_DIGIT_0 + sym_w - {2'b00, SYM_DIGIT_BASE};
        end else if (sym == SYM_PLUS) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

    // Alphabet character to six-bit symbol, with pad and invalid flags.
    function automatic t_sym dec_sym(input logic [7:0] ch);
        t_sym       s;
        logic [7:0] diff;
        s    = '0;
        diff = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            diff    = ch - CHAR_UPPER_A;
            s.value = diff[5:0];
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            diff    = ch - CHAR_LOWER_A + {2'b00, SYM_LOWER_BASE};
            s.value = diff[5:0];
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            diff    = ch - CHAR_DIGIT_0 + {2'b00, SYM_DIGIT_BASE};
            s.value = diff[5:0];
        end else if (ch == CHAR_PLUS) begin
            s.value = SYM_PLUS;
        end else if (ch == CHAR_SLASH) begin
            s.value = SYM_SLASH;
        end else if (ch == CHAR_PAD) begin
            s.is_pad = 1'b1;
        end else begin
            s.is_bad = 1'b1;
        end
        return s;
    endfunction

endpackage

[design/base64_stream_codec.sv]
// Streaming base64 codec: input register, group step logic, result buffer.
// The input register and the result buffer lie between an input transfer and its first result.
// Throughput: one item per cycle while the result buffer has room; encode is
// limited by the result channel to four characters per three bytes, decode to
// one character per cycle; receiver stalls add.
// Reset (synchronous, active low) clears the mode to encode and empties all.
`timescale 1ns / 1ps

module base64_stream_codec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  b64_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output b64_pkg::t_out_item o_data
);

    import b64_pkg::*;

    logic     r_mode;
    logic     r_in_valid;
    t_in_item r_in;
    t_burst   burst;
    logic     buf_free;
    logic     step;
    logic     load;
    logic     accept;

    // Direction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // The held item moves on when its results fit in the buffer.
    assign step    = r_in_valid && (burst.count == '0 || buf_free);
    assign load    = step && (burst.count != '0);
    assign o_stall = r_in_valid && !step;
    assign accept  = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
    end

    b64_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_clear (i_cfg_wr_en),
        .i_step  (step),
        .i_item  (r_in),
        .o_burst (burst)
    );

    b64_burst_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .o_free  (buf_free)
    );

`ifndef SYNTHESIS
    // A burst is only loaded into an empty or emptying buffer.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> buf_free)
        else $error("burst loaded over undelivered results");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // An error result carries a zero data byte.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.bad_input) |-> (o_data.out_data == 8'h00))
        else $error("error result with non-zero data");

    // Encoding never reports bad input.
    a_enc_no_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == MODE_ENCODE) |-> !o_data.bad_input)
        else $error("error result in encode mode");
`endif

endmodule

[design/b64_group.sv]
// Group state and single-pass step logic of the base64 codec.
// Holds the gathered bits, byte or symbol count and pad count; depends on b64_pkg.
`timescale 1ns / 1ps

module b64_group (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic             i_clear,
    input  logic             i_step,
    input  b64_pkg::t_in_item i_item,
    output b64_pkg::t_burst  o_burst
);

    import b64_pkg::*;

    logic [23:0] r_bits;
    logic [1:0]  r_count;
    logic [1:0]  r_pads;
    logic [23:0] n_bits;
    logic [1:0]  n_count;
    logic [1:0]  n_pads;

    logic [23:0] merged;
    logic [1:0]  fill;
    logic [23:0] shifted;
    logic [1:0]  pads_upd;
    logic [1:0]  nbytes;
    t_sym        sym;
    t_burst      burst;

    // Encode: slot the byte into the group.
    always_comb begin
        unique case (r_count)
            2'd0:    merged = r_bits | {i_item.in_data, 16'h0000};
            2'd1:    merged = r_bits | {8'h00, i_item.in_data, 8'h00};
            2'd2:    merged = r_bits | {16'h0000, i_item.in_data};
            default: merged = r_bits;
        endcase
        fill = r_count + 2'd1;
    end

    // Decode: classify the character and shift its six bits in.
    always_comb begin
        sym      = dec_sym(i_item.in_data);
        pads_upd = sym.is_pad ? (r_pads + 2'd1) : r_pads;
        shifted  = {r_bits[17:0], (sym.is_pad ? 6'd0 : sym.value)};
        nbytes   = 2'd3 - pads_upd;
    end

    // Next group state and the results of this item.
    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        n_pads  = r_pads;
        burst   = '0;
        if (i_mode == MODE_ENCODE) begin
            if (fill == 2'd3 || i_item.is_last) begin
                burst.count             = 3'd4;
                burst.items[0].out_data = enc_char(merged[23:18]);
                burst.items[1].out_data = enc_char(merged[17:12]);
                burst.items[2].out_data = (fill == 2'd1) ? CHAR_PAD
                                                         : enc_char(merged[11:6]);
                burst.items[3].out_data = (fill == 2'd1 || fill == 2'd2) ? CHAR_PAD
                                                         : enc_char(merged[5:0]);
                burst.items[3].out_last = i_item.is_last;
                n_bits  = '0;
                n_count = '0;
                n_pads  = '0;
            end else begin
                n_bits  = merged;
                n_count = fill;
            end
        end else begin
            if (sym.is_bad || (sym.is_pad && r_count < 2'd2) ||
                (!sym.is_pad && r_pads != 2'd0)) begin
                // Invalid character, misplaced pad or data after pad.
                burst.count              = 3'd1;
                burst.items[0].out_last  = i_item.is_last;
                burst.items[0].bad_input = 1'b1;
                n_bits  = '0;
                n_count = '0;
                n_pads  = '0;
            end else if (r_count != 2'd3) begin
                if (i_item.is_last) begin
                    // Final group left unfinished.
                    burst.count              = 3'd1;
                    burst.items[0].out_last  = 1'b1;
                    burst.items[0].bad_input = 1'b1;
                    n_bits  = '0;
                    n_count = '0;
                    n_pads  = '0;
                end else begin
                    n_bits  = shifted;
                    n_count = r_count + 2'd1;
                    n_pads  = pads_upd;
                end
            end else begin
                // Group complete: give one to three bytes.
                burst.items[0].out_data = shifted[23:16];
                burst.items[1].out_data = shifted[15:8];
                burst.items[2].out_data = shifted[7:0];
                unique case (nbytes)
                    2'd3: begin
                        burst.count             = 3'd3;
                        burst.items[2].out_last = i_item.is_last;
                    end
                    2'd2: begin
                        burst.count             = 3'd2;
                        burst.items[1].out_last = i_item.is_last;
                    end
                    2'd1: begin
                        burst.count             = 3'd1;
                        burst.items[0].out_last = i_item.is_last;
                    end
                    default: begin
                        burst.count = 3'd0;
                    end
                endcase
                n_bits  = '0;
                n_count = '0;
                n_pads  = '0;
            end
        end
    end

    // Group registers: cleared on reset and on any direction write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bits  <= '0;
            r_count <= '0;
            r_pads  <= '0;
        end else if (i_step) begin
            r_bits  <= n_bits;
            r_count <= n_count;
            r_pads  <= n_pads;
        end
    end

    assign o_burst = burst;

endmodule

[design/b64_burst_buf.sv]
// Result buffer of the base64 codec: holds the results of one item and
// hands them out one transfer per cycle unless the receiver stalls. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_burst_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  b64_pkg::t_burst    i_burst,
    input  logic               i_stall,
    output logic               o_valid,
    output b64_pkg::t_out_item o_data,
    output logic               o_free
);

    import b64_pkg::*;

    t_out_item [BurstMax-1:0] r_items;
    logic [BurstCntW-1:0]     r_rem;
    logic                     take;

    assign o_valid = (r_rem != '0);
    assign o_data  = r_items[0];
    assign take    = o_valid && !i_stall;
    // Room for a new burst once the last held result leaves.
    assign o_free  = (r_rem == '0) || (r_rem == BurstCntW'(1) && take);

    // Result payload: load a burst or shift towards the head.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_burst.items;
        end else if (take) begin
            r_items[BurstMax-2:0] <= r_items[BurstMax-1:1];
        end
    end

    // Count of results still to be transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_burst.count;
        end else if (take) begin
            r_rem <= r_rem - BurstCntW'(1);
        end
    end

endmodule

[test/base64_stream_codec_test.sv]
// Self-checking testbench for base64_stream_codec: directed and random encode
// and decode traffic with random idling on both channels, checked per transfer.
// Depends on b64_pkg and the base64_stream_codec top level only.
`timescale 1ns / 1ps

module base64_stream_codec_test;
    import b64_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PCT      = 30;
    localparam int CALM_FIRST    = 120;
    localparam int CALM_LAST     = 200;
    localparam int CYCLE_LIMIT   = 100000;

    // Character classes returned by char_sym besides a six-bit value.
    localparam int SYM_IS_PAD = -1;
    localparam int SYM_IS_BAD = -2;

    typedef enum {ACT_ITEM, ACT_CFG, ACT_DRAIN} t_act_kind;

    typedef struct {
        t_act_kind kind;
        t_in_item  item;
        logic      mode;
    } t_stim_act;

    logic      i_clk         = 1'b0;
    logic      i_rst_n       = 1'b0;
    logic      i_cfg_wr_en   = 1'b0;
    logic      i_cfg_wr_data = MODE_ENCODE;
    logic      i_valid       = 1'b0;
    t_in_item  i_data        = '0;
    logic      i_stall       = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;

    string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Codec state as the testbench sees it.
    logic        codec_mode  = MODE_ENCODE;
    logic [23:0] group_acc   = '0;
    logic [1:0]  group_fill  = '0;
    logic [1:0]  group_pads  = '0;

    t_out_item   expected_q[$];
    t_stim_act   pending_q[$];
    int          stim_items   = 0;
    int          accepted_cnt = 0;
    int          quiet_cnt    = 0;
    int          err_cnt      = 0;
    int          cycle_cnt    = 0;
    logic        calm         = 1'b0;

    base64_stream_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data        (i_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Codec prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] sym_char(input logic [5:0] s);
        return alphabet[int'(s)];
    endfunction

    // Six-bit value of a text character, or one of the two class codes.
    function automatic int char_sym(input logic [7:0] c);
        if (c == CHAR_PAD) begin
            return SYM_IS_PAD;
        end
        for (int k = 0; k < 64; k++) begin
            if (alphabet[k] == c) begin
                return k;
            end
        end
        return SYM_IS_BAD;
    endfunction

    function automatic void clear_group();
        group_acc  = '0;
        group_fill = '0;
        group_pads = '0;
    endfunction

    function automatic void push_expected(input logic [7:0] d, input logic last,
                                          input logic bad);
        t_out_item e;
        e.out_data  = d;
        e.out_last  = last;
        e.bad_input = bad;
        expected_q.push_back(e);
    endfunction

    // Works out the results of one accepted input transfer.
    function automatic void predict_codec(input t_in_item it);
        int sym;
        int n;
        if (codec_mode == MODE_ENCODE) begin
            group_acc  = group_acc | ({16'b0, it.in_data} << (8 * (2 - group_fill)));
            n          = group_fill + 1;
            group_fill = group_fill + 2'd1;
            if (n == 3 || it.is_last) begin
                // A short group is zero-filled and padded out to four characters.
                push_expected(sym_char(group_acc[23:18]), 1'b0, 1'b0);
                push_expected(sym_char(group_acc[17:12]), 1'b0, 1'b0);
                push_expected((n >= 2) ? sym_char(group_acc[11:6]) : CHAR_PAD, 1'b0, 1'b0);
                push_expected((n == 3) ? sym_char(group_acc[5:0]) : CHAR_PAD,
                              it.is_last, 1'b0);
                clear_group();
            end
        end else begin
            sym = char_sym(it.in_data);
            if (sym == SYM_IS_BAD || (sym == SYM_IS_PAD && group_fill < 2) ||
                (sym != SYM_IS_PAD && group_pads != 0)) begin
                // Bad character, early pad or data after a pad.
                push_expected(8'h00, it.is_last, 1'b1);
                clear_group();
            end else begin
                if (sym == SYM_IS_PAD) begin
                    group_pads = group_pads + 2'd1;
                    sym        = 0;
                end
                group_acc = {group_acc[17:0], sym[5:0]};
                if (group_fill < 3) begin
                    group_fill = group_fill + 2'd1;
                    // The message ends inside an unfinished group.
                    if (it.is_last) begin
                        push_expected(8'h00, 1'b1, 1'b1);
                        clear_group();
                    end
                end else begin
                    n = 3 - group_pads;
                    for (int k = 0; k < n; k++) begin
                        push_expected(group_acc[8 * (2 - k) +: 8],
                                      (k == n - 1) ? it.is_last : 1'b0, 1'b0);
                    end
                    clear_group();
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void add_item(input logic [7:0] d, input logic last);
        t_stim_act a;
        a.kind         = ACT_ITEM;
        a.item.in_data = d;
        a.item.is_last = last;
        a.mode         = MODE_ENCODE;
        pending_q.push_back(a);
        stim_items++;
    endfunction

    function automatic void add_cfg(input logic m);
        t_stim_act a;
        a.kind = ACT_CFG;
        a.item = '0;
        a.mode = m;
        pending_q.push_back(a);
    endfunction

    function automatic void add_drain();
        t_stim_act a;
        a.kind = ACT_DRAIN;
        a.item = '0;
        a.mode = MODE_ENCODE;
        pending_q.push_back(a);
    endfunction

    function automatic void add_text(input string s, input logic last);
        for (int k = 0; k < s.len(); k++) begin
            add_item(s[k], last && (k == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_sym_char();
        return alphabet[$urandom_range(0, 63)];
    endfunction

    // Four symbols, the last npad of them pads.
    function automatic void add_group(input int npad, input logic last);
        for (int k = 0; k < 4; k++) begin
            add_item((k >= 4 - npad) ? CHAR_PAD : rand_sym_char(), last && (k == 3));
        end
    endfunction

    function automatic void add_encode_msg();
        int len;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
            add_item(8'($urandom_range(0, 255)),
                     (k == len - 1) && ($urandom_range(0, 7) != 0));
        end
    endfunction

    // Mostly well-formed text, the rest noise and broken groups.
    function automatic void add_decode_msg();
        int full;
        int tail;
        int pos;
        full = $urandom_range(0, 3);
        for (int g = 0; g < full; g++) begin
            add_group(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0, 1'b0);
        end
        case ($urandom_range(0, 9))
            6: begin
                // Message stops part way through a group.
                tail = $urandom_range(1, 3);
                for (int k = 0; k < tail; k++) begin
                    add_item(rand_sym_char(), k == tail - 1);
                end
            end
            7: begin
                // Arbitrary bytes.
                tail = $urandom_range(1, 4);
                for (int k = 0; k < tail; k++) begin
                    add_item(8'($urandom_range(0, 255)),
                             (k == tail - 1) && ($urandom_range(0, 1) != 0));
                end
            end
            8, 9: begin
                // Pad too early, or a data character after a pad.
                pos = $urandom_range(0, 2);
                for (int k = 0; k < 4; k++) begin
                    add_item((k == pos) ? CHAR_PAD : rand_sym_char(), k == 3);
                end
            end
            default: begin
                add_group($urandom_range(0, 2), 1'b1);
            end
        endcase
    endfunction

    function automatic void build_stimulus();
        int   target;
        int   phase_end;
        logic mode;
        // Directed encode: full group, one and two bytes left, cut-off group.
        add_cfg(MODE_ENCODE);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h80, 1'b1);
        add_item(8'hFF, 1'b1);
        add_item(8'h01, 1'b0);
        add_item(8'hFE, 1'b1);
        add_item(8'h4D, 1'b0);
        // Directed decode: two pads, padded group mid-stream, bad character,
        // pads in the first and second place, data after a pad, short ending.
        add_cfg(MODE_DECODE);
        add_text("TQ==", 1'b1);
        add_text("+/E=", 1'b0);
        add_drain();
        add_item(8'hFF, 1'b0);
        add_item(CHAR_PAD, 1'b1);
        add_text("A=", 1'b0);
        add_text("AB=C", 1'b0);
        add_text("AB", 1'b1);

        target = stim_items + RANDOM_ITEMS;
        while (stim_items < target) begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_DECODE : MODE_ENCODE;
            add_cfg(mode);
            phase_end = stim_items + $urandom_range(40, 70);
            // The last phase stops at the item budget.
            if (phase_end > target) begin
                phase_end = target;
            end
            while (stim_items < phase_end) begin
                if (mode == MODE_ENCODE) begin
                    add_encode_msg();
                end else begin
                    add_decode_msg();
                end
                if ($urandom_range(0, 14) == 0) begin
                    add_drain();
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: input transfers and register writes
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        logic     nxt_valid;
        t_in_item nxt_data;
        logic     nxt_wr_en;
        logic     nxt_wr_data;
        logic     idle;
        if (i_rst_n) begin
            nxt_valid   = i_valid;
            nxt_data    = i_data;
            nxt_wr_en   = 1'b0;
            nxt_wr_data = i_cfg_wr_data;

            if (i_valid && !o_stall) begin
                predict_codec(i_data);
                accepted_cnt++;
                nxt_valid = 1'b0;
            end
            // Count the cycles since anything last moved on either channel.
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cnt = 0;
            end else begin
                quiet_cnt++;
            end
            idle = (expected_q.size() == 0) && (quiet_cnt >= SETTLE_CYCLES);

            if (!nxt_valid && pending_q.size() != 0) begin
                case (pending_q[0].kind)
                    ACT_ITEM: begin
                        if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                            nxt_valid = 1'b1;
                            nxt_data  = pending_q[0].item;
                            void'(pending_q.pop_front());
                        end
                    end
                    ACT_CFG: begin
                        if (idle) begin
                            nxt_wr_en   = 1'b1;
                            nxt_wr_data = pending_q[0].mode;
                            codec_mode  = pending_q[0].mode;
                            clear_group();
                            void'(pending_q.pop_front());
                        end
                    end
                    default: begin
                        if (idle) begin
                            void'(pending_q.pop_front());
                        end
                    end
                endcase
            end

            i_valid       <= nxt_valid;
            i_data        <= nxt_data;
            i_cfg_wr_en   <= nxt_wr_en;
            i_cfg_wr_data <= nxt_wr_data;
            calm          <= (accepted_cnt >= CALM_FIRST) && (accepted_cnt < CALM_LAST);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result transfers and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result data %h last %b bad %b",
                                          o_data.out_data, o_data.out_last,
                                          o_data.bad_input));
            end else begin
                want = expected_q.pop_front();
                if (o_data.out_data !== want.out_data ||
                    o_data.out_last !== want.out_last ||
                    o_data.bad_input !== want.bad_input) begin
                    report_mismatch($sformatf(
                        "got data %h last %b bad %b, wanted data %h last %b bad %b",
                        o_data.out_data, o_data.out_last, o_data.bad_input,
                        want.out_data, want.out_last, want.bad_input));
                end
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("base64_stream_codec test failed");
        $finish;
    end

    initial begin
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait for the last transfer, then give stray results time to show.
        while (pending_q.size() != 0 || i_valid || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4 * SETTLE_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("base64_stream_codec test passed");
        end else begin
            $display("base64_stream_codec test failed");
        end
        $finish;
    end

endmodule

[files.f]
design/b64_pkg.sv
design/b64_group.sv
design/b64_burst_buf.sv
design/base64_stream_codec.sv
test/base64_stream_codec_test.sv
